// ===== rtl/core/m3inv_pkg.sv =====
// m3inv_pkg: widths, reset constants and types for the 3x3 matrix inverse unit
// used by m3inv_div and matrix3x3_inverse_unit; depends on nothing

package m3inv_pkg;

	// entry format
	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int THR_W  = 31;

	// derived widths
	localparam int PROD_W = 2 * DATA_W;
	localparam int COF_W  = 2 * DATA_W + 1;
	localparam int PART_W = 2 * DATA_W + 1;
	localparam int DET_W  = 3 * DATA_W + 3;
	localparam int NUM_W  = (2 * DATA_W + 2 * FRAC_W + 2 > 3 * DATA_W + 3) ?
		2 * DATA_W + 2 * FRAC_W + 2 : 3 * DATA_W + 3;
	localparam int CMP_W  = DET_W + THR_W + 2 * FRAC_W;
	localparam int DIV_LAT = DATA_W + 1;

	// threshold after reset: round(0.01 in the entry format)
	localparam logic [THR_W-1:0] THR_RESET =
		THR_W'(((64'd1 << FRAC_W) + 64'd50) / 64'd100);

	// per-item sideband that travels alongside the dividers
	typedef struct packed {
		logic       vld;
		logic       sing;
		logic [8:0] neg;
	} side_t;

endpackage

// ===== rtl/core/m3inv_div.sv =====
// m3inv_div: pipelined restoring divider, one quotient bit per stage
// depends on m3inv_pkg; a new operand pair every cycle

module m3inv_div
	import m3inv_pkg::*;
(
	input  logic              clk,
	input  logic [NUM_W-1:0]  num,
	input  logic [NUM_W-1:0]  den,
	output logic [DATA_W-1:0] quo,
	output logic              big
);

	localparam int SH_W = NUM_W + DATA_W;

	logic [NUM_W-1:0]  rem_s [0:DATA_W];
	logic [NUM_W-1:0]  den_s [0:DATA_W];
	logic [DATA_W-1:0] quo_s [0:DATA_W];
	logic              big_s [0:DATA_W];

	// first stage: flag quotients that do not fit the word
	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		big_s[0] <= SH_W'(num) >= (SH_W'(den) << DATA_W);
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < DATA_W; k++) begin : g_bit
		localparam int BIT = DATA_W - 1 - k;
		logic [SH_W-1:0] dsh;
		logic            ge;

		always_comb begin
			dsh = SH_W'(den_s[k]) << BIT;
			ge  = SH_W'(rem_s[k]) >= dsh;
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_s[k] - dsh[NUM_W-1:0] : rem_s[k];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= quo_s[k] | (DATA_W'(ge) << BIT);
			big_s[k+1] <= big_s[k];
		end
	end

	assign quo = quo_s[DATA_W];
	assign big = big_s[DATA_W];

endmodule

// ===== rtl/core/matrix3x3_inverse_unit.sv =====
// matrix3x3_inverse_unit: 3x3 inverse by adjugate over determinant, signed Q16.16
// depends on m3inv_pkg and m3inv_div
// pipeline: 7 arithmetic stages, 33 divider stages and one output register lie between
// taking the word and done; throughput: one matrix per cycle,
// busy stays low since every stage advances each cycle
// reset clears valid bits and sets the threshold to 655; no clearing pass

module matrix3x3_inverse_unit
	import m3inv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] m00, m01, m02,
	input  logic signed [DATA_W-1:0] m10, m11, m12,
	input  logic signed [DATA_W-1:0] m20, m21, m22,
	input  logic                     cfg_we,
	input  logic [THR_W-1:0]         cfg_wdata,
	output logic                     done,
	output logic signed [DATA_W-1:0] inv00, inv01, inv02,
	output logic signed [DATA_W-1:0] inv10, inv11, inv12,
	output logic signed [DATA_W-1:0] inv20, inv21, inv22,
	output logic                     singular
);

	logic signed [DATA_W-1:0] m_in [9];
	logic [THR_W-1:0]         thr_q;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [PROD_W-1:0] pa_s1 [9];
	logic signed [PROD_W-1:0] pb_s1 [9];
	logic signed [DATA_W-1:0] e0_s1 [3];
	logic signed [COF_W-1:0]  cof_s2 [9];
	logic signed [DATA_W-1:0] e0_s2 [3];
	logic signed [COF_W-1:0]  cof_s3 [9];
	logic signed [PART_W-1:0] plo_s3 [3];
	logic signed [PART_W-1:0] phi_s3 [3];
	logic signed [COF_W-1:0]  cof_s4 [9];
	logic signed [DET_W-1:0]  t_s4 [3];
	logic signed [COF_W-1:0]  cof_s5 [9];
	logic signed [DET_W-1:0]  det_s5;
	logic [COF_W-1:0]         acof_s6 [9];
	logic [DET_W-1:0]         adet_s6;
	logic [8:0]               neg_s6;
	logic [NUM_W-1:0]         num_s7 [9];
	logic [NUM_W-1:0]         den_s7;
	logic [8:0]               neg_s7;
	logic                     sing_s7;

	side_t                    side_s [0:DIV_LAT-1];
	logic [DATA_W-1:0]        quo [9];
	logic                     big [9];
	logic [DATA_W-1:0]        res_q [9];
	logic                     done_q, sing_q;

	assign busy = 1'b0;

	assign m_in[0] = m00; assign m_in[1] = m01; assign m_in[2] = m02;
	assign m_in[3] = m10; assign m_in[4] = m11; assign m_in[5] = m12;
	assign m_in[6] = m20; assign m_in[7] = m21; assign m_in[8] = m22;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// valid bits along the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
		end
	end

	// stage 1: minor products; stage 2: signed cofactors
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			localparam int R1 = (r == 0) ? 1 : 0;
			localparam int R2 = (r == 2) ? 1 : 2;
			localparam int C1 = (c == 0) ? 1 : 0;
			localparam int C2 = (c == 2) ? 1 : 2;
			localparam int J  = r * 3 + c;

			always_ff @(posedge clk) begin
				pa_s1[J] <= m_in[R1*3+C1] * m_in[R2*3+C2];
				pb_s1[J] <= m_in[R1*3+C2] * m_in[R2*3+C1];
				if (((r + c) % 2) == 1) begin
					cof_s2[J] <= {pb_s1[J][PROD_W-1], pb_s1[J]} -
						{pa_s1[J][PROD_W-1], pa_s1[J]};
				end else begin
					cof_s2[J] <= {pa_s1[J][PROD_W-1], pa_s1[J]} -
						{pb_s1[J][PROD_W-1], pb_s1[J]};
				end
			end
		end
	end

	// stages 3 and 4: first-row terms of the determinant as split products
	for (genvar c = 0; c < 3; c++) begin : g_det
		always_ff @(posedge clk) begin
			e0_s1[c]  <= m_in[c];
			e0_s2[c]  <= e0_s1[c];
			plo_s3[c] <= e0_s2[c] * $signed({1'b0, cof_s2[c][DATA_W-1:0]});
			phi_s3[c] <= e0_s2[c] * $signed(cof_s2[c][COF_W-1:DATA_W]);
			t_s4[c]   <= (DET_W'(phi_s3[c]) <<< DATA_W) + DET_W'(plo_s3[c]);
		end
	end

	// stages 3 to 7: cofactor magnitudes, determinant, divider operands
	for (genvar j = 0; j < 9; j++) begin : g_cof
		always_ff @(posedge clk) begin
			cof_s3[j]  <= cof_s2[j];
			cof_s4[j]  <= cof_s3[j];
			cof_s5[j]  <= cof_s4[j];
			acof_s6[j] <= cof_s5[j][COF_W-1] ? COF_W'(-cof_s5[j]) : COF_W'(cof_s5[j]);
			neg_s6[j]  <= cof_s5[j][COF_W-1] ^ det_s5[DET_W-1];
			num_s7[j]  <= (NUM_W'(acof_s6[j]) << (2 * FRAC_W + 1)) + NUM_W'(adet_s6);
			neg_s7[j]  <= neg_s6[j];
		end
	end

	always_ff @(posedge clk) begin
		det_s5  <= t_s4[0] + t_s4[1] + t_s4[2];
		adet_s6 <= det_s5[DET_W-1] ? DET_W'(-det_s5) : DET_W'(det_s5);
		den_s7  <= NUM_W'(adet_s6) << 1;
		sing_s7 <= (adet_s6 == '0) ||
			(CMP_W'(adet_s6) < (CMP_W'(thr_q) << (2 * FRAC_W)));
	end

	// sideband delay line matching the divider latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[0] <= '0;
		end else begin
			side_s[0] <= '{vld: vld_s7, sing: sing_s7, neg: neg_s7};
		end
	end

	for (genvar k = 1; k < DIV_LAT; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// one divider per output entry; inverse entry (r,c) takes cofactor (c,r)
	for (genvar k = 0; k < 9; k++) begin : g_lane
		localparam int SRC = (k % 3) * 3 + (k / 3);
		logic              ovf;
		logic [DATA_W-1:0] sat;

		m3inv_div u_div (
			.clk    (clk),
			.num    (num_s7[SRC]),
			.den    (den_s7),
			.quo    (quo[k]),
			.big    (big[k])
		);

		// saturate to the word range, zero on a singular matrix
		always_comb begin
			if (side_s[DIV_LAT-1].neg[SRC]) begin
				ovf = big[k] || (quo[k][DATA_W-1] && (quo[k][DATA_W-2:0] != '0));
				sat = ovf ? (DATA_W'(1) << (DATA_W - 1)) : DATA_W'(-quo[k]);
			end else begin
				ovf = big[k] || quo[k][DATA_W-1];
				sat = ovf ? ~(DATA_W'(1) << (DATA_W - 1)) : quo[k];
			end
		end

		always_ff @(posedge clk) begin
			res_q[k] <= side_s[DIV_LAT-1].sing ? '0 : sat;
		end
	end

	// output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_s[DIV_LAT-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		sing_q <= side_s[DIV_LAT-1].sing;
	end

	assign done     = done_q;
	assign singular = sing_q;
	assign inv00 = res_q[0]; assign inv01 = res_q[1]; assign inv02 = res_q[2];
	assign inv10 = res_q[3]; assign inv11 = res_q[4]; assign inv12 = res_q[5];
	assign inv20 = res_q[6]; assign inv21 = res_q[7]; assign inv22 = res_q[8];

endmodule
